// ===== sv/base64_decoder_assert.svh =====
// Assertion macros shared by the base64 decoder modules.
`ifndef BASE64_DECODER_ASSERT_SVH
`define BASE64_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define B64D_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define B64D_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/b64d_pkg.sv =====
// Types, constants and the alphabet lookup for the base64 decoder.
`default_nettype none

package b64d_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int LEN_OUT_W       = 16;
    localparam int BYTE_W          = 8;
    localparam int GROUP_W         = 24;

    localparam logic [BYTE_W-1:0] CHAR_EQ    = 8'h3D;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_LO_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [BYTE_W-1:0] CHAR_D0    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_D9    = 8'h39;
    localparam logic [BYTE_W-1:0] BYTE_MASK  = 8'hFF;

    localparam logic [1:0] SLOT_FIRST = 2'd0;
    localparam logic [1:0] SLOT_LAST  = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] text_char;
        logic              final_char;
    } t_char;

    // Results caused by one character: three bytes, one status result, or both.
    typedef struct packed {
        logic                 has_bytes;
        logic [GROUP_W-1:0]   bytes;
        logic                 done;
        logic                 err;
        logic [LEN_OUT_W-1:0] len;
    } t_bundle;

    // {ok, six-bit value}
    function automatic logic [6:0] sextet(input logic [BYTE_W-1:0] ch);
        logic [6:0] r;
        r = 7'd0;
        if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z) begin
            r = {1'b1, 6'(ch - CHAR_UP_A)};
        end else if (ch >= CHAR_LO_A && ch <= CHAR_LO_Z) begin
            r = {1'b1, 6'((ch - CHAR_LO_A) + 8'd26)};
        end else if (ch >= CHAR_D0 && ch <= CHAR_D9) begin
            r = {1'b1, 6'((ch - CHAR_D0) + 8'd52)};
        end else if (ch == CHAR_PLUS) begin
            r = {1'b1, 6'd62};
        end else if (ch == CHAR_SLASH) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/b64d_skid.sv =====
// Two-entry input skid buffer; ready toward the sender is registered.
`default_nettype none

module b64d_skid (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire b64d_pkg::t_char i_data,
    output logic                 o_valid,
    output b64d_pkg::t_char      o_data,
    input  wire logic            i_pop
);

    logic            r_main_valid;
    logic            r_skid_valid;
    b64d_pkg::t_char r_main_data;
    b64d_pkg::t_char r_skid_data;
    logic            acc;
    logic            main_free;

    assign o_ready   = !r_skid_valid;
    assign acc       = i_valid && !r_skid_valid;
    assign main_free = !r_main_valid || i_pop;
    assign o_valid   = r_main_valid;
    assign o_data    = r_main_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (main_free) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= acc;
            end
        end else if (acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (main_free) begin
            r_main_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (acc) begin
            r_skid_data <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/b64d_core.sv =====
// Group assembly, padding and length counters; one character per cycle unless one with results waits for output room.
`default_nettype none

`include "base64_decoder_assert.svh"

module b64d_core #(
    parameter int LENGTH_BITS = b64d_pkg::LENGTH_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire b64d_pkg::t_char i_data,
    output logic                 o_pop,
    input  wire logic            i_free,
    output logic                 o_push,
    output b64d_pkg::t_bundle    o_bundle
);

    localparam int GW = b64d_pkg::GROUP_W;
    localparam int LW = b64d_pkg::LEN_OUT_W;
    localparam int DW = (LENGTH_BITS > LW) ? LENGTH_BITS : LW;

    logic [GW-1:0]          r_group, n_group;
    logic [1:0]             r_slot, n_slot;
    logic [LENGTH_BITS-1:0] r_pad, n_pad;
    logic [LENGTH_BITS-1:0] r_bytes, n_bytes;
    logic                   r_err, n_err;

    logic [7:0]             ch;
    logic                   last;
    logic [6:0]             sx;
    logic                   is_pad;
    logic                   ch_ok;
    logic [5:0]             bits;
    logic [GW-1:0]          g;
    logic                   complete;
    logic                   err_fin;
    logic                   produces;
    logic                   advance;
    logic [LENGTH_BITS:0]   pad_sum;
    logic [LENGTH_BITS:0]   byte_sum;
    logic [LENGTH_BITS-1:0] pad_inc;
    logic [LENGTH_BITS-1:0] bytes_inc;
    logic [LENGTH_BITS-1:0] diff;
    logic [DW-1:0]          diff_ext;

    assign ch   = i_data.text_char;
    assign last = i_data.final_char;

    assign pad_sum   = {1'b0, r_pad} + (LENGTH_BITS+1)'(1);
    assign byte_sum  = {1'b0, r_bytes} + (LENGTH_BITS+1)'(3);
    assign pad_inc   = pad_sum[LENGTH_BITS] ? '1 : pad_sum[LENGTH_BITS-1:0];
    assign bytes_inc = byte_sum[LENGTH_BITS] ? '1 : byte_sum[LENGTH_BITS-1:0];

    always_comb begin
        sx     = b64d_pkg::sextet(ch);
        is_pad = (ch == b64d_pkg::CHAR_EQ);
        ch_ok  = is_pad || sx[6];
        bits   = is_pad ? 6'd0 : sx[5:0];

        case (r_slot)
            2'd0:    g = r_group | {bits, 18'd0};
            2'd1:    g = r_group | {6'd0, bits, 12'd0};
            2'd2:    g = r_group | {12'd0, bits, 6'd0};
            default: g = r_group | {18'd0, bits};
        endcase

        n_group  = r_group;
        n_slot   = r_slot;
        n_pad    = r_pad;
        n_bytes  = r_bytes;
        n_err    = r_err;
        complete = 1'b0;

        if (!r_err) begin
            if (is_pad) begin
                n_pad = pad_inc;
            end
            if (!ch_ok) begin
                n_err   = 1'b1;
                n_group = '0;
                n_slot  = b64d_pkg::SLOT_FIRST;
            end else if (r_slot == b64d_pkg::SLOT_LAST) begin
                complete = 1'b1;
                n_bytes  = bytes_inc;
                n_group  = '0;
                n_slot   = b64d_pkg::SLOT_FIRST;
            end else begin
                n_group = g;
                n_slot  = r_slot + 2'd1;
            end
        end

        // a string that stops partway through a group is also an error
        err_fin  = n_err || (n_slot != b64d_pkg::SLOT_FIRST);
        diff     = (n_bytes > n_pad) ? (n_bytes - n_pad) : '0;
        diff_ext = DW'(diff);

        o_bundle.has_bytes = complete;
        o_bundle.bytes     = g;
        o_bundle.done      = last;
        o_bundle.err       = last && err_fin;
        o_bundle.len       = (last && !err_fin) ? diff_ext[LW-1:0] : '0;

        produces = complete || last;

        if (last) begin
            n_group = '0;
            n_slot  = b64d_pkg::SLOT_FIRST;
            n_pad   = '0;
            n_bytes = '0;
            n_err   = 1'b0;
        end
    end

    // only characters that emit results wait for room at the output
    assign advance = i_valid && (!produces || i_free);
    assign o_pop   = advance;
    assign o_push  = advance && produces;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group <= '0;
            r_slot  <= b64d_pkg::SLOT_FIRST;
            r_pad   <= '0;
            r_bytes <= '0;
            r_err   <= 1'b0;
        end else if (advance) begin
            r_group <= n_group;
            r_slot  <= n_slot;
            r_pad   <= n_pad;
            r_bytes <= n_bytes;
            r_err   <= n_err;
        end
    end

    `B64D_ASSERT_IMP(a_err_group_clear, r_err, (r_group == '0) && (r_slot == 2'd0), "group not clear after error")
    `B64D_ASSERT_IMP(a_slot1_low_clear, r_slot == 2'd1, r_group[17:0] == '0, "bits below slot set")
    `B64D_ASSERT_NXT(a_final_resets, advance && last, (r_slot == 2'd0) && !r_err && (r_bytes == '0), "state not reset after final")

endmodule

`default_nettype wire

// ===== sv/b64d_outq.sv =====
// Result register: holds one bundle and hands out its results one per cycle while the receiver is ready.
`default_nettype none

`include "base64_decoder_assert.svh"

module b64d_outq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire b64d_pkg::t_bundle i_bundle,
    output logic                   o_free,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_data_byte,
    output logic                   o_byte_valid,
    output logic                   o_run_end,
    output logic                   o_string_done,
    output logic                   o_decode_error,
    output logic [15:0]            o_decoded_length
);

    logic              r_valid;
    logic [1:0]        r_idx;
    b64d_pkg::t_bundle r_bund;
    logic              last_res;
    logic              pop;

    assign last_res = !r_bund.has_bytes || (r_idx == 2'd2);
    assign pop      = r_valid && i_ready;
    assign o_free   = !r_valid || (pop && last_res);
    assign o_valid  = r_valid;

    always_comb begin
        case (r_idx)
            2'd0:    o_data_byte = r_bund.bytes[23:16];
            2'd1:    o_data_byte = r_bund.bytes[15:8];
            default: o_data_byte = r_bund.bytes[7:0];
        endcase
        if (!r_bund.has_bytes) begin
            o_data_byte = '0;
        end
    end

    assign o_byte_valid     = r_bund.has_bytes;
    assign o_run_end        = last_res;
    assign o_string_done    = r_bund.done && last_res;
    assign o_decode_error   = r_bund.err && last_res;
    assign o_decoded_length = last_res ? r_bund.len : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (o_free && i_push) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (pop && last_res) begin
            r_valid <= 1'b0;
        end else if (pop) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_push) begin
            r_bund <= i_bundle;
        end
    end

    `B64D_ASSERT_IMP(a_idx_range, r_valid, r_idx != 2'd3, "result index out of range")
    `B64D_ASSERT_IMP(a_status_single, r_valid && !r_bund.has_bytes, r_idx == 2'd0, "status result not first")
    `B64D_ASSERT_NXT(a_bundle_holds, pop && !last_res, r_valid && (r_idx == $past(r_idx) + 2'd1), "bundle dropped early")

endmodule

`default_nettype wire

// ===== sv/base64_decoder.sv =====
// Base64 decoder top level: input skid buffer, decode core, result register.
//
// Input stream: one ASCII character per transfer on i_s_axis_tdata, with
// i_s_axis_tlast marking the final character of a string. Output stream: one
// result per transfer; tdata carries the decoded byte and the end-of-string
// status, tuser says whether a byte is present, tlast ends the results of
// one character. Each fourth character of a group yields three byte results;
// the final character yields the string status (length or error), riding on
// the third byte when it completes a clean group.
// A character passes through the skid buffer's registers and then the result
// register before its first result is offered. Throughput: one character per
// cycle while the receiver keeps up, set by the single decode stage between the
// skid buffer and the result register; the output side moves one result per
// cycle while the receiver is ready, so a 4-character group's bytes go out in turn.
// Reset (synchronous, active low) empties both buffers and clears the group,
// padding and byte counters and the error flag. When the receiver stalls, the
// result register holds; characters that emit no results still pass, and once a
// character needing output is blocked the skid buffer fills and o_s_axis_tready drops.
`default_nettype none

module base64_decoder #(
    parameter int LENGTH_BITS = b64d_pkg::LENGTH_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] text_char
    input  wire logic        i_s_axis_tlast,   // final_char
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [7:0] data_byte, [8] string_done,
                                               // [9] decode_error, [25:10] decoded_length
    output logic             o_m_axis_tuser,   // byte_valid
    output logic             o_m_axis_tlast    // run_end
);

    b64d_pkg::t_char   in_char;
    b64d_pkg::t_char   core_char;
    b64d_pkg::t_bundle bundle;
    logic              core_valid;
    logic              core_pop;
    logic              q_free;
    logic              q_push;
    logic [7:0]        data_byte;
    logic              string_done;
    logic              decode_error;
    logic [15:0]       decoded_length;

    assign in_char.text_char  = i_s_axis_tdata;
    assign in_char.final_char = i_s_axis_tlast;

    b64d_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (in_char),
        .o_valid (core_valid),
        .o_data  (core_char),
        .i_pop   (core_pop)
    );

    b64d_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (core_valid),
        .i_data   (core_char),
        .o_pop    (core_pop),
        .i_free   (q_free),
        .o_push   (q_push),
        .o_bundle (bundle)
    );

    b64d_outq u_outq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (q_push),
        .i_bundle         (bundle),
        .o_free           (q_free),
        .o_valid          (o_m_axis_tvalid),
        .i_ready          (i_m_axis_tready),
        .o_data_byte      (data_byte),
        .o_byte_valid     (o_m_axis_tuser),
        .o_run_end        (o_m_axis_tlast),
        .o_string_done    (string_done),
        .o_decode_error   (decode_error),
        .o_decoded_length (decoded_length)
    );

    assign o_m_axis_tdata = {6'd0, decoded_length, decode_error, string_done, data_byte};

endmodule

`default_nettype wire
